@@ hdl/osd_pkg.sv @@
// shared types, codes and constants of the opcode stream decoder
package osd_pkg;

  localparam int unsigned WordW     = 16;
  localparam int unsigned MnemW     = 6;
  localparam int unsigned AddrW     = 12;
  localparam int unsigned IdxW      = 11;
  localparam int unsigned StatW     = 2;
  localparam int unsigned OutDataW  = 72;
  localparam int unsigned LoadBaseDefault = 512;
  localparam int unsigned LastAddr  = 4094;

  // result status codes
  localparam logic [StatW-1:0] ST_OK      = 2'd0;
  localparam logic [StatW-1:0] ST_INVALID = 2'd1;
  localparam logic [StatW-1:0] ST_ZERO    = 2'd2;

  // dense mnemonic codes
  localparam logic [MnemW-1:0] MN_CLS      = 6'd0;
  localparam logic [MnemW-1:0] MN_RET      = 6'd1;
  localparam logic [MnemW-1:0] MN_JP       = 6'd2;
  localparam logic [MnemW-1:0] MN_CALL     = 6'd3;
  localparam logic [MnemW-1:0] MN_SE_VK    = 6'd4;
  localparam logic [MnemW-1:0] MN_SNE_VK   = 6'd5;
  localparam logic [MnemW-1:0] MN_SE_VV    = 6'd6;
  localparam logic [MnemW-1:0] MN_LD_VK    = 6'd7;
  localparam logic [MnemW-1:0] MN_ADD_VK   = 6'd8;
  localparam logic [MnemW-1:0] MN_LD_VV    = 6'd9;
  localparam logic [MnemW-1:0] MN_SHL      = 6'd17;
  localparam logic [MnemW-1:0] MN_SNE_VV   = 6'd18;
  localparam logic [MnemW-1:0] MN_LD_I     = 6'd19;
  localparam logic [MnemW-1:0] MN_JP_V0    = 6'd20;
  localparam logic [MnemW-1:0] MN_RND      = 6'd21;
  localparam logic [MnemW-1:0] MN_DRW      = 6'd22;
  localparam logic [MnemW-1:0] MN_SKP      = 6'd23;
  localparam logic [MnemW-1:0] MN_SKNP     = 6'd24;
  localparam logic [MnemW-1:0] MN_LD_VDT   = 6'd25;
  localparam logic [MnemW-1:0] MN_LD_VKEY  = 6'd26;
  localparam logic [MnemW-1:0] MN_LD_DT    = 6'd27;
  localparam logic [MnemW-1:0] MN_LD_ST    = 6'd28;
  localparam logic [MnemW-1:0] MN_ADD_I    = 6'd29;
  localparam logic [MnemW-1:0] MN_LD_F     = 6'd30;
  localparam logic [MnemW-1:0] MN_LD_B     = 6'd31;
  localparam logic [MnemW-1:0] MN_ST_REGS  = 6'd32;
  localparam logic [MnemW-1:0] MN_LD_REGS  = 6'd33;

  // special words and sub-op bytes
  localparam logic [WordW-1:0] W_CLS = 16'h00e0;
  localparam logic [WordW-1:0] W_RET = 16'h00ee;
  localparam logic [3:0] SUB8_SHL   = 4'he;
  localparam logic [7:0] SUBE_SKP   = 8'h9e;
  localparam logic [7:0] SUBE_SKNP  = 8'ha1;
  localparam logic [7:0] SUBF_VDT   = 8'h07;
  localparam logic [7:0] SUBF_VKEY  = 8'h0a;
  localparam logic [7:0] SUBF_DT    = 8'h15;
  localparam logic [7:0] SUBF_ST    = 8'h18;
  localparam logic [7:0] SUBF_ADDI  = 8'h1e;
  localparam logic [7:0] SUBF_FONT  = 8'h29;
  localparam logic [7:0] SUBF_BCD   = 8'h33;
  localparam logic [7:0] SUBF_STR   = 8'h55;
  localparam logic [7:0] SUBF_LDR   = 8'h65;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [MnemW-1:0] mnemonic;
  } osd_dec_t;

endpackage

@@ hdl/osd_decoder.sv @@
// combinational classifier of one instruction word into status and mnemonic
module osd_decoder
  import osd_pkg::*;
(
  input  logic [WordW-1:0] word,
  output osd_dec_t         dec
);

  logic [3:0]       top;
  logic [3:0]       lo4;
  logic [7:0]       lo8;
  logic             bad;
  logic [MnemW-1:0] mn;

  assign top = word[15:12];
  assign lo4 = word[3:0];
  assign lo8 = word[7:0];

  always_comb begin
    bad = 1'b0;
    mn  = MN_CLS;
    case (top)
      4'h0: begin
        if (word == W_CLS) mn = MN_CLS;
        else if (word == W_RET) mn = MN_RET;
        else bad = 1'b1;
      end
      4'h1: mn = MN_JP;
      4'h2: mn = MN_CALL;
      4'h3: mn = MN_SE_VK;
      4'h4: mn = MN_SNE_VK;
      4'h5: begin
        mn  = MN_SE_VV;
        bad = (lo4 != 4'h0);
      end
      4'h6: mn = MN_LD_VK;
      4'h7: mn = MN_ADD_VK;
      4'h8: begin
        // arithmetic group: sub-ops 0..7 map densely after LD Vx,Vy
        if (!lo4[3]) mn = MN_LD_VV + {3'b000, lo4[2:0]};
        else if (lo4 == SUB8_SHL) mn = MN_SHL;
        else bad = 1'b1;
      end
      4'h9: begin
        mn  = MN_SNE_VV;
        bad = (lo4 != 4'h0);
      end
      4'ha: mn = MN_LD_I;
      4'hb: mn = MN_JP_V0;
      4'hc: mn = MN_RND;
      4'hd: mn = MN_DRW;
      4'he: begin
        if (lo8 == SUBE_SKP) mn = MN_SKP;
        else if (lo8 == SUBE_SKNP) mn = MN_SKNP;
        else bad = 1'b1;
      end
      default: begin
        case (lo8)
          SUBF_VDT:  mn = MN_LD_VDT;
          SUBF_VKEY: mn = MN_LD_VKEY;
          SUBF_DT:   mn = MN_LD_DT;
          SUBF_ST:   mn = MN_LD_ST;
          SUBF_ADDI: mn = MN_ADD_I;
          SUBF_FONT: mn = MN_LD_F;
          SUBF_BCD:  mn = MN_LD_B;
          SUBF_STR:  mn = MN_ST_REGS;
          SUBF_LDR:  mn = MN_LD_REGS;
          default:   bad = 1'b1;
        endcase
      end
    endcase

    if (word == '0) begin
      dec.status   = ST_ZERO;
      dec.mnemonic = MN_CLS;
    end else if (bad) begin
      dec.status   = ST_INVALID;
      dec.mnemonic = MN_CLS;
    end else begin
      dec.status   = ST_OK;
      dec.mnemonic = mn;
    end
  end

endmodule

@@ hdl/opcode_stream_decoder_unit.sv @@
// top level of the opcode stream decoder: handshake, program counter, result register
//
// usage
//   input channel: one instruction word per handshake on in_tdata, in_tuser
//   flags the first word of a program (clears the instruction index and
//   restarts decoding). output channel: one decoded word per handshake, the
//   status code on out_tuser and the extracted fields on out_tdata.
// result register and throughput
//   the result of an accepted word is registered and shows at out_tvalid in
//   the next cycle; one word is accepted every cycle, limited only by the single
//   output register and the receiver's out_tready.
// reset
//   the block comes out of reset stopped: words are accepted but dropped
//   until one arrives with the first-word flag set. an all-zero word or an
//   invalid word is reported and stops the stream again.
// stalls
//   while a result waits with out_tready low, in_tready is low too; a word
//   that gives no result is still taken whenever in_tready is high.
module opcode_stream_decoder_unit
  import osd_pkg::*;
#(
  parameter int unsigned LOAD_BASE = LoadBaseDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [WordW-1:0]    in_tdata,   // [15:0] opcode
  input  logic [0:0]          in_tuser,   // [0] first_word
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [5:0] mnemonic, [9:6] reg_x, [13:10] reg_y,
                                          // [17:14] nibble_imm, [25:18] byte_imm,
                                          // [37:26] addr_imm, [49:38] instr_address,
                                          // [50] label_here, [66:51] raw_word, zero pad
  output logic [StatW-1:0]    out_tuser   // [1:0] status
);

  // last index whose address still fits below the top of memory
  localparam int unsigned BaseMod  = LOAD_BASE % 4096;
  localparam int unsigned LimRaw   = (BaseMod > LastAddr) ? 0 : (LastAddr - BaseMod) / 2;
  localparam int unsigned LimInt   = (LimRaw > 2047) ? 2047 : LimRaw;
  localparam logic [IdxW-1:0]  IdxLimit = IdxW'(LimInt);
  localparam logic [AddrW-1:0] BaseAddr = AddrW'(BaseMod);

  // program state
  logic [IdxW-1:0] index_r, index_nxt;
  logic            stopped_r, stopped_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0] out_data_r;
  logic [StatW-1:0]    out_stat_r;

  logic            in_acc;
  logic            first;
  logic            active;
  logic            emit;
  logic [IdxW-1:0] idx_cur;
  logic [AddrW-1:0] instr_addr;
  logic            label;
  osd_dec_t        dec;
  logic [OutDataW-1:0] data_nxt;

  osd_decoder u_dec (
    .word (in_tdata),
    .dec  (dec)
  );

  // the output register frees up in the same cycle the receiver takes it
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign first     = in_tuser[0];
  assign active    = first || !stopped_r;
  assign emit      = in_acc && active;
  assign idx_cur   = first ? '0 : index_r;

  assign instr_addr = BaseAddr + {idx_cur, 1'b0};
  assign label      = (idx_cur[1:0] == 2'b00);

  assign data_nxt = {5'b00000, in_tdata, label, instr_addr, in_tdata[11:0], in_tdata[7:0],
                     in_tdata[3:0], in_tdata[7:4], in_tdata[11:8], dec.mnemonic};

  always_comb begin
    index_nxt   = index_r;
    stopped_nxt = stopped_r;
    if (emit) begin
      // any non-ok word ends the program; index saturates at the limit
      stopped_nxt = (dec.status != ST_OK);
      if (dec.status == ST_OK && idx_cur < IdxLimit) index_nxt = idx_cur + 1'b1;
      else index_nxt = idx_cur;
    end
  end

  always_comb begin
    if (in_acc) out_valid_nxt = emit;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r     <= '0;
      stopped_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      index_r     <= index_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= data_nxt;
      out_stat_r <= dec.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

`ifndef SYNTHESIS
  a_reset_stops: assert property (@(posedge clk) !rst_n |=> stopped_r)
    else $error("decoder not stopped after reset");

  a_index_limit: assert property (@(posedge clk) disable iff (!rst_n) index_r <= IdxLimit)
    else $error("instruction index past its limit");

  a_drop_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && stopped_r && !first) |=> (stopped_r && $stable(index_r)))
    else $error("dropped word changed program state");

  a_bad_word_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && dec.status != ST_OK) |=> (stopped_r && out_tvalid && out_tuser != ST_OK))
    else $error("end or invalid word did not stop the stream");
`endif

endmodule
